>>> hdl/rvas_pkg.sv
// Shared types and constants for the reverse adjoint sweep.
// Used by rvas_front, rvas_back and reverse_adjoint_sweep; no dependencies.
package rvas_pkg;

    localparam int TAPE_DEPTH_DEF = 64;
    localparam int FRAC_BITS_DEF  = 16;
    localparam int QW             = 32;
    localparam int PW             = 6;

    typedef struct packed {
        logic signed [QW-1:0] partial_first;
        logic signed [QW-1:0] partial_second;
        logic [PW-1:0]        parent_first;
        logic [PW-1:0]        parent_second;
        logic                 has_first;
        logic                 has_second;
        logic                 last_entry;
    } t_entry;

endpackage

>>> hdl/rvas_front.sv
// Input side: takes tape words and holds them in a two-slot queue.
// Depends on rvas_pkg for the packed entry type.
module rvas_front
    import rvas_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic signed [QW-1:0] i_partial_first,
    input  logic signed [QW-1:0] i_partial_second,
    input  logic [PW-1:0]        i_parent_first,
    input  logic [PW-1:0]        i_parent_second,
    input  logic                 i_has_first,
    input  logic                 i_has_second,
    input  logic                 i_last_entry,
    output logic                 o_q_vld,
    output t_entry               o_q_word,
    input  logic                 i_q_pop
);

    t_entry     r_slot [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_fill;
    logic       push;
    logic       pop;
    t_entry     in_word;

    always_comb begin
        in_word.partial_first  = i_partial_first;
        in_word.partial_second = i_partial_second;
        in_word.parent_first   = i_parent_first;
        in_word.parent_second  = i_parent_second;
        in_word.has_first      = i_has_first;
        in_word.has_second     = i_has_second;
        in_word.last_entry     = i_last_entry;
    end

    assign o_ready  = (r_fill != 2'd2);
    assign push     = i_valid && o_ready;
    assign pop      = i_q_pop && o_q_vld;
    assign o_q_vld  = (r_fill != 2'd0);
    assign o_q_word = r_slot[r_rp];

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_slot[r_wp] <= in_word;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp   <= 1'b0;
            r_rp   <= 1'b0;
            r_fill <= 2'd0;
        end else begin
            if (push) begin
                r_wp <= ~r_wp;
            end
            if (pop) begin
                r_rp <= ~r_rp;
            end
            case ({push, pop})
                2'b10:   r_fill <= r_fill + 2'd1;
                2'b01:   r_fill <= r_fill - 2'd1;
                default: r_fill <= r_fill;
            endcase
        end
    end

endmodule

>>> hdl/rvas_back.sv
// Tape storage and backward sweep engine with the result register.
// Depends on rvas_pkg; fed by rvas_front through its queue.
module rvas_back
    import rvas_pkg::*;
#(
    parameter int TAPE_DEPTH    = TAPE_DEPTH_DEF,
    parameter int FRACTION_BITS = FRAC_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_q_vld,
    input  t_entry               i_q_word,
    output logic                 o_q_pop,
    output logic                 o_valid,
    input  logic                 i_ready,
    output logic [PW-1:0]        o_entry_index,
    output logic signed [QW-1:0] o_adjoint,
    output logic                 o_saturated,
    output logic                 o_bad_link,
    output logic                 o_last_result
);

    localparam int AW = (TAPE_DEPTH > 1) ? $clog2(TAPE_DEPTH) : 1;
    localparam int CW = $clog2(TAPE_DEPTH + 1);
    localparam int LW = 2 * PW + 2;

    localparam logic [2:0] S_LOAD = 3'd0;
    localparam logic [2:0] S_RD   = 3'd1;
    localparam logic [2:0] S_EMIT = 3'd2;
    localparam logic [2:0] S_ARD  = 3'd3;
    localparam logic [2:0] S_TERM = 3'd4;
    localparam logic [2:0] S_SUM  = 3'd5;

    localparam logic signed [2*QW-1:0] HALF  = 64'sd1 <<< (FRACTION_BITS - 1);
    localparam logic signed [2*QW-1:0] QMAX  = 64'sd2147483647;
    localparam logic signed [2*QW-1:0] QMIN  = -64'sd2147483648;
    localparam logic signed [QW-1:0]   SEED  = 32'sd1 <<< FRACTION_BITS;
    localparam logic signed [QW-1:0]   MAX32 = 32'sh7FFFFFFF;
    localparam logic signed [QW-1:0]   MIN32 = 32'sh80000000;

    logic [2*QW-1:0] r_partial_mem [TAPE_DEPTH];
    logic [LW-1:0]   r_link_mem    [TAPE_DEPTH];
    logic [QW:0]     r_adj_mem     [TAPE_DEPTH];

    logic [2:0]             r_state;
    logic [CW-1:0]          r_cnt;
    logic [AW-1:0]          r_idx;
    logic [TAPE_DEPTH-1:0]  r_avld;
    logic [2*QW-1:0]        r_part_rd;
    logic [LW-1:0]          r_link_rd;
    logic [QW:0]            r_adj_rd;
    logic                   r_rd_vld;
    logic signed [QW-1:0]   r_adj;
    logic signed [QW-1:0]   r_part2;
    logic [AW-1:0]          r_p2;
    logic                   r_more;
    logic [AW-1:0]          r_par;
    logic signed [QW-1:0]   r_psel;
    logic signed [2*QW-1:0] r_prod;
    logic signed [QW-1:0]   r_term;
    logic                   r_tsat;
    logic                   r_out_vld;
    logic [PW-1:0]          r_out_idx;
    logic signed [QW-1:0]   r_out_adj;
    logic                   r_out_sat;
    logic                   r_out_bad;
    logic                   r_out_last;

    logic                   full;
    logic [AW-1:0]          ld_top;
    logic                   tape_we;
    logic                   adj_we;
    logic [AW-1:0]          adj_wa;
    logic [QW:0]            adj_wd;
    logic                   rd_en;
    logic [AW-1:0]          rd_addr;
    logic [PW-1:0]          idx_ext;
    logic [PW-1:0]          lk_p1;
    logic [PW-1:0]          lk_p2;
    logic                   lk_h1;
    logic                   lk_h2;
    logic                   ok1;
    logic                   ok2;
    logic                   bad;
    logic signed [QW-1:0]   cur_adj;
    logic                   cur_sat;
    logic                   out_free;
    logic signed [2*QW-1:0] rnd;
    logic signed [2*QW-1:0] shr;
    logic signed [QW-1:0]   term_v;
    logic                   term_sat;
    logic signed [QW-1:0]   old_v;
    logic signed [QW:0]     sum33;
    logic                   sum_sat;
    logic signed [QW-1:0]   sum_v;

    assign full    = (r_cnt == CW'(TAPE_DEPTH));
    assign ld_top  = full ? AW'(TAPE_DEPTH - 1) : r_cnt[AW-1:0];
    assign o_q_pop = (r_state == S_LOAD) && i_q_vld;
    assign tape_we = o_q_pop && !full;

    assign idx_ext = PW'(r_idx);
    assign lk_p1   = r_link_rd[PW-1:0];
    assign lk_p2   = r_link_rd[2*PW-1:PW];
    assign lk_h1   = r_link_rd[2*PW];
    assign lk_h2   = r_link_rd[2*PW+1];
    assign ok1     = lk_h1 && (lk_p1 < idx_ext);
    assign ok2     = lk_h2 && (lk_p2 < idx_ext);
    assign bad     = (lk_h1 && !ok1) || (lk_h2 && !ok2);
    assign cur_adj = r_rd_vld ? $signed(r_adj_rd[QW-1:0]) : '0;
    assign cur_sat = r_rd_vld && r_adj_rd[QW];
    assign out_free = !r_out_vld || i_ready;

    assign rnd = r_prod + HALF;
    assign shr = rnd >>> FRACTION_BITS;
    always_comb begin
        term_sat = 1'b0;
        term_v   = shr[QW-1:0];
        if (shr > QMAX) begin
            term_sat = 1'b1;
            term_v   = MAX32;
        end else if (shr < QMIN) begin
            term_sat = 1'b1;
            term_v   = MIN32;
        end
    end

    assign old_v   = cur_adj;
    assign sum33   = {old_v[QW-1], old_v} + {r_term[QW-1], r_term};
    assign sum_sat = (sum33[QW] != sum33[QW-1]);
    assign sum_v   = sum_sat ? (sum33[QW] ? MIN32 : MAX32) : sum33[QW-1:0];

    always_comb begin
        adj_we = 1'b0;
        adj_wa = r_par;
        adj_wd = {cur_sat || r_tsat || sum_sat, sum_v};
        if (o_q_pop && i_q_word.last_entry) begin
            adj_we = 1'b1;
            adj_wa = ld_top;
            adj_wd = {1'b0, SEED};
        end else if (r_state == S_SUM) begin
            adj_we = 1'b1;
        end
    end

    assign rd_en   = (r_state == S_RD) || (r_state == S_ARD);
    assign rd_addr = (r_state == S_RD) ? r_idx : r_par;

    always_ff @(posedge i_clk) begin
        if (tape_we) begin
            r_partial_mem[r_cnt[AW-1:0]] <= {i_q_word.partial_second, i_q_word.partial_first};
            r_link_mem[r_cnt[AW-1:0]]    <= {i_q_word.has_second, i_q_word.has_first,
                                             i_q_word.parent_second, i_q_word.parent_first};
        end
        if (r_state == S_RD) begin
            r_part_rd <= r_partial_mem[r_idx];
            r_link_rd <= r_link_mem[r_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (adj_we) begin
            r_adj_mem[adj_wa] <= adj_wd;
        end
        if (rd_en) begin
            r_adj_rd <= r_adj_mem[rd_addr];
            r_rd_vld <= r_avld[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_EMIT) begin
            r_adj   <= cur_adj;
            r_part2 <= $signed(r_part_rd[2*QW-1:QW]);
            r_p2    <= lk_p2[AW-1:0];
        end
        if (r_state == S_ARD) begin
            r_prod <= r_adj * r_psel;
        end
        if (r_state == S_TERM) begin
            r_term <= term_v;
            r_tsat <= term_sat;
        end
        if (r_state == S_EMIT && out_free) begin
            r_out_idx  <= idx_ext;
            r_out_adj  <= cur_adj;
            r_out_sat  <= cur_sat;
            r_out_bad  <= bad;
            r_out_last <= (r_idx == '0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_LOAD;
            r_cnt     <= '0;
            r_idx     <= '0;
            r_avld    <= '0;
            r_more    <= 1'b0;
            r_par     <= '0;
            r_psel    <= '0;
            r_out_vld <= 1'b0;
        end else begin
            if (r_state == S_EMIT && out_free) begin
                r_out_vld <= 1'b1;
            end else if (r_out_vld && i_ready) begin
                r_out_vld <= 1'b0;
            end
            case (r_state)
                S_LOAD: begin
                    if (o_q_pop) begin
                        if (!full) begin
                            r_cnt <= r_cnt + CW'(1);
                        end
                        if (i_q_word.last_entry) begin
                            r_idx   <= ld_top;
                            r_avld  <= {{(TAPE_DEPTH-1){1'b0}}, 1'b1} << ld_top;
                            r_state <= S_RD;
                        end
                    end
                end
                S_RD: begin
                    r_state <= S_EMIT;
                end
                S_EMIT: begin
                    if (out_free) begin
                        if (ok1) begin
                            r_par   <= lk_p1[AW-1:0];
                            r_psel  <= $signed(r_part_rd[QW-1:0]);
                            r_more  <= ok2;
                            r_state <= S_ARD;
                        end else if (ok2) begin
                            r_par   <= lk_p2[AW-1:0];
                            r_psel  <= $signed(r_part_rd[2*QW-1:QW]);
                            r_more  <= 1'b0;
                            r_state <= S_ARD;
                        end else if (r_idx == '0) begin
                            r_cnt   <= '0;
                            r_state <= S_LOAD;
                        end else begin
                            r_idx   <= r_idx - AW'(1);
                            r_state <= S_RD;
                        end
                    end
                end
                S_ARD: begin
                    r_state <= S_TERM;
                end
                S_TERM: begin
                    r_state <= S_SUM;
                end
                S_SUM: begin
                    r_avld[r_par] <= 1'b1;
                    if (r_more) begin
                        r_par   <= r_p2;
                        r_psel  <= r_part2;
                        r_more  <= 1'b0;
                        r_state <= S_ARD;
                    end else if (r_idx == '0) begin
                        r_cnt   <= '0;
                        r_state <= S_LOAD;
                    end else begin
                        r_idx   <= r_idx - AW'(1);
                        r_state <= S_RD;
                    end
                end
                default: begin
                    r_state <= S_LOAD;
                end
            endcase
        end
    end

    assign o_valid       = r_out_vld;
    assign o_entry_index = r_out_idx;
    assign o_adjoint     = r_out_adj;
    assign o_saturated   = r_out_sat;
    assign o_bad_link    = r_out_bad;
    assign o_last_result = r_out_last;

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CW'(TAPE_DEPTH))
        else $error("tape count beyond depth");

    a_idx_in_tape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_LOAD) |-> (CW'(r_idx) < r_cnt))
        else $error("sweep position outside loaded tape");

    a_parent_below: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ARD) |-> (r_par < r_idx))
        else $error("accumulation target not below current entry");

    a_seed_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RD) && $past(r_state == S_LOAD) |-> r_avld[r_idx])
        else $error("top entry not seeded at sweep start");

endmodule

>>> hdl/reverse_adjoint_sweep.sv
// Reverse adjoint sweep over a gradient tape of up to TAPE_DEPTH entries.
// Loading: one word per cycle while no sweep runs; the two-slot queue lets the
// input run ahead. Sweep: each entry passes S_RD then S_EMIT, each valid parent
// link S_ARD, S_TERM, S_SUM; S_EMIT stalls until the result register is free.
// Reset clears control, the queue and the adjoint valid bits; tape memories are
// not cleared. Top level; depends on rvas_pkg, rvas_front and rvas_back.
module reverse_adjoint_sweep
    import rvas_pkg::*;
#(
    parameter int TAPE_DEPTH    = TAPE_DEPTH_DEF,
    parameter int FRACTION_BITS = FRAC_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic signed [QW-1:0] i_partial_first,
    input  logic signed [QW-1:0] i_partial_second,
    input  logic [PW-1:0]        i_parent_first,
    input  logic [PW-1:0]        i_parent_second,
    input  logic                 i_has_first,
    input  logic                 i_has_second,
    input  logic                 i_last_entry,
    output logic                 o_valid,
    input  logic                 i_ready,
    output logic [PW-1:0]        o_entry_index,
    output logic signed [QW-1:0] o_adjoint,
    output logic                 o_saturated,
    output logic                 o_bad_link,
    output logic                 o_last_result
);

    logic   q_vld;
    logic   q_pop;
    t_entry q_word;

    rvas_front u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_ready          (o_ready),
        .i_partial_first  (i_partial_first),
        .i_partial_second (i_partial_second),
        .i_parent_first   (i_parent_first),
        .i_parent_second  (i_parent_second),
        .i_has_first      (i_has_first),
        .i_has_second     (i_has_second),
        .i_last_entry     (i_last_entry),
        .o_q_vld          (q_vld),
        .o_q_word         (q_word),
        .i_q_pop          (q_pop)
    );

    rvas_back #(
        .TAPE_DEPTH    (TAPE_DEPTH),
        .FRACTION_BITS (FRACTION_BITS)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_q_vld       (q_vld),
        .i_q_word      (q_word),
        .o_q_pop       (q_pop),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_entry_index (o_entry_index),
        .o_adjoint     (o_adjoint),
        .o_saturated   (o_saturated),
        .o_bad_link    (o_bad_link),
        .o_last_result (o_last_result)
    );

endmodule
